@@ hw/rtl/admission_rate_limiter_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef ADMISSION_RATE_LIMITER_UNIT_DEFINES_SVH
`define ADMISSION_RATE_LIMITER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ARL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ARL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/arl_pkg.sv @@
package arl_pkg;

   // Request beat
   typedef struct packed {
      logic [31:0] now_time;
      logic        maintenance;
      logic        override;
   } req_type;

   // Response beat
   typedef struct packed {
      logic       accepted;
      logic [2:0] reason_code;
   } rsp_type;

   // Refusal reasons
   localparam logic [2:0] RSN_OK     = 3'd0;
   localparam logic [2:0] RSN_MAINT  = 3'd1;
   localparam logic [2:0] RSN_COOL   = 3'd2;
   localparam logic [2:0] RSN_GAP    = 3'd3;
   localparam logic [2:0] RSN_WINDOW = 3'd4;

   // Control register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PER_WINDOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GAP         = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_LENGTH = 2'd3;
   localparam int unsigned CSR_DATA_W = 24;

   // Control register reset values
   localparam logic [23:0] WINDOW_LENGTH_RST   = 24'd10000;
   localparam logic [15:0] MAX_PER_WINDOW_RST  = 16'd3;
   localparam logic [23:0] MIN_GAP_RST         = 24'd500;
   localparam logic [23:0] COOLDOWN_LENGTH_RST = 24'd3000;

endpackage

@@ hw/rtl/admission_rate_limiter_unit.sv @@
// Path: a taken request beat goes into the input register, then decision
//    logic feeds the response register.
// Throughput: one request per cycle when not stalled; the decision path is
//    a few 33-bit adds and compares on the window, gap and cooldown registers.
// Reset: synchronous, active high; clears both stages, the window state and
//    loads the control registers with their default values.
module admission_rate_limiter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  arl_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output arl_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [arl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [arl_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Control registers
   logic [23:0] window_length_ff;
   logic [15:0] max_per_window_ff;
   logic [23:0] min_gap_ff;
   logic [23:0] cooldown_length_ff;

   // Limiter state
   logic [31:0] window_start_ff, window_start_in;
   logic [15:0] window_count_ff, window_count_in;
   logic [31:0] last_accept_ff, last_accept_in;
   logic        any_accepted_ff, any_accepted_in;
   logic [32:0] cooldown_end_ff, cooldown_end_in;

   // Pipeline registers
   logic             stage_valid_ff;
   arl_pkg::req_type stage_data_ff;
   logic             rsp_valid_ff;
   arl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        advance;
   logic [32:0] window_end;
   logic        roll;
   logic [15:0] count_eff;
   logic [32:0] gap_diff;
   logic        gap_short;

   // Handshakes: stage moves when the response register is free or drains
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= arl_pkg::WINDOW_LENGTH_RST;
         max_per_window_ff  <= arl_pkg::MAX_PER_WINDOW_RST;
         min_gap_ff         <= arl_pkg::MIN_GAP_RST;
         cooldown_length_ff <= arl_pkg::COOLDOWN_LENGTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            arl_pkg::CSR_WINDOW_LENGTH:   window_length_ff   <= csr_data;
            arl_pkg::CSR_MAX_PER_WINDOW:  max_per_window_ff  <= csr_data[15:0];
            arl_pkg::CSR_MIN_GAP:         min_gap_ff         <= csr_data;
            arl_pkg::CSR_COOLDOWN_LENGTH: cooldown_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Decide on the staged request
   always_comb begin
      window_end = {1'b0, window_start_ff} + {9'd0, window_length_ff};
      roll       = {1'b0, stage_data_ff.now_time} >= window_end;
      count_eff  = roll ? 16'd0 : window_count_ff;
      gap_diff   = {1'b0, stage_data_ff.now_time} - {1'b0, last_accept_ff};
      // negative gap always counts as short
      gap_short  = gap_diff[32] || (gap_diff[31:0] < {8'd0, min_gap_ff});

      window_start_in = roll ? stage_data_ff.now_time : window_start_ff;
      window_count_in = count_eff;
      last_accept_in  = last_accept_ff;
      any_accepted_in = any_accepted_ff;
      cooldown_end_in = cooldown_end_ff;
      rsp_data_in     = '{accepted: 1'b0, reason_code: arl_pkg::RSN_OK};

      if (stage_data_ff.maintenance && !stage_data_ff.override) begin
         rsp_data_in.reason_code = arl_pkg::RSN_MAINT;
      end else if ({1'b0, stage_data_ff.now_time} < cooldown_end_ff) begin
         rsp_data_in.reason_code = arl_pkg::RSN_COOL;
      end else if (any_accepted_ff && gap_short) begin
         rsp_data_in.reason_code = arl_pkg::RSN_GAP;
      end else if (count_eff >= max_per_window_ff) begin
         rsp_data_in.reason_code = arl_pkg::RSN_WINDOW;
         cooldown_end_in = {1'b0, stage_data_ff.now_time} + {9'd0, cooldown_length_ff};
      end else begin
         rsp_data_in.accepted = 1'b1;
         last_accept_in       = stage_data_ff.now_time;
         any_accepted_in      = 1'b1;
         window_count_in      = count_eff + 16'd1;
      end
   end

   // Advance the pipeline and commit state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_start_ff <= '0;
         window_count_ff <= '0;
         last_accept_ff  <= '0;
         any_accepted_ff <= 1'b0;
         cooldown_end_ff <= '0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            window_start_ff <= window_start_in;
            window_count_ff <= window_count_in;
            last_accept_ff  <= last_accept_in;
            any_accepted_ff <= any_accepted_in;
            cooldown_end_ff <= cooldown_end_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold payloads without reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ hw/rtl/arl_checker.sv @@
`include "admission_rate_limiter_unit_defines.svh"

module arl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input arl_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input arl_pkg::rsp_type                rsp_data,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [arl_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [arl_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_valid, csr_ready, csr_index, csr_data};

   // Response holds while stalled
   `ARL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   // Accept flag agrees with the reason
   `ARL_ASSERT(a_acc_reason, clock, reset, rsp_valid |-> (rsp_data.accepted == (rsp_data.reason_code == arl_pkg::RSN_OK)), "accept flag and reason disagree")

   // Reason stays in the defined set
   `ARL_ASSERT(a_reason_range, clock, reset, rsp_valid |-> (rsp_data.reason_code <= arl_pkg::RSN_WINDOW), "undefined reason code")

   // No response right after reset
   `ARL_ASSERT_ALWAYS(a_reset_empty, clock, $fell(reset) |-> !rsp_valid && req_ready, "pipeline not empty after reset")

   // Input side never refuses while nothing is in flight or being held
   `ARL_ASSERT(a_ready_idle, clock, reset, !rsp_valid && !$past(req_valid && req_ready) |-> req_ready, "request refused while empty")

endmodule

bind admission_rate_limiter_unit arl_checker u_arl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

@@ verif/admission_rate_limiter_unit_test.sv @@
module admission_rate_limiter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          DRAIN_CYCLES  = 4;
   localparam longint      STAMP_CEILING = 64'hF000_0000;
   localparam int          SHOWN_ERRORS  = 10;
   localparam logic [23:0] FIELD24_MAX   = 24'hFFFFFF;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   arl_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   arl_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [arl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [arl_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the control registers
   logic [23:0] cfg_window;
   logic [15:0] cfg_max;
   logic [23:0] cfg_min_gap;
   logic [23:0] cfg_cooldown;

   // Shadow copy of the window, gap and cooldown state
   logic [31:0] win_start;
   logic [15:0] win_count;
   logic [31:0] last_admit;
   logic        admitted_any;
   logic [32:0] cool_until;

   arl_pkg::rsp_type verdict_q[$];
   int          cycle_count = 0;
   int          mismatches = 0;
   int          results_seen = 0;
   int          requests_sent = 0;
   int          settings_loaded = 0;
   int          reason_seen[5] = '{default: 0};
   int          ready_left = 0;
   int          ready_roll;
   bit          sender_steady = 1'b0;
   longint      stamp_cursor = 0;

   admission_rate_limiter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  verdict_q.size());
         $display("FAIL admission_rate_limiter_unit");
         $finish;
      end
   end

   // Stall the response side: mostly short runs, a few long stalls and long open stretches
   always @(posedge clock) begin
      if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 55) begin
            rsp_ready  <= 1'b1;
            ready_left <= $urandom_range(0, 6);
         end else if (ready_roll < 90) begin
            rsp_ready  <= 1'b0;
            ready_left <= $urandom_range(0, 2);
         end else if (ready_roll < 95) begin
            rsp_ready  <= 1'b0;
            ready_left <= $urandom_range(8, 30);
         end else begin
            rsp_ready  <= 1'b1;
            ready_left <= $urandom_range(40, 120);
         end
      end
   end

   // Compare each response beat with the oldest predicted verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (rsp_data.reason_code <= arl_pkg::RSN_WINDOW)
            reason_seen[rsp_data.reason_code] <= reason_seen[rsp_data.reason_code] + 1;
         if (verdict_q.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < SHOWN_ERRORS)
               $display("response %0d arrived with nothing predicted: accepted=%0b reason=%0d",
                        results_seen, rsp_data.accepted, rsp_data.reason_code);
         end else begin
            if (rsp_data.accepted !== verdict_q[0].accepted ||
                rsp_data.reason_code !== verdict_q[0].reason_code) begin
               mismatches <= mismatches + 1;
               if (mismatches < SHOWN_ERRORS)
                  $display("response %0d: expected accepted=%0b reason=%0d, got accepted=%0b reason=%0d",
                           results_seen, verdict_q[0].accepted, verdict_q[0].reason_code,
                           rsp_data.accepted, rsp_data.reason_code);
            end
            void'(verdict_q.pop_front());
         end
      end
   end

   // Return registers and window state to their reset values
   function automatic void reset_shadow();
      cfg_window   = arl_pkg::WINDOW_LENGTH_RST;
      cfg_max      = arl_pkg::MAX_PER_WINDOW_RST;
      cfg_min_gap  = arl_pkg::MIN_GAP_RST;
      cfg_cooldown = arl_pkg::COOLDOWN_LENGTH_RST;
      win_start    = '0;
      win_count    = '0;
      last_admit   = '0;
      admitted_any = 1'b0;
      cool_until   = '0;
   endfunction

   function automatic void apply_setting(input logic [arl_pkg::CSR_INDEX_W-1:0] idx,
                                         input logic [arl_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         arl_pkg::CSR_WINDOW_LENGTH:   cfg_window   = value[23:0];
         arl_pkg::CSR_MAX_PER_WINDOW:  cfg_max      = value[15:0];
         arl_pkg::CSR_MIN_GAP:         cfg_min_gap  = value[23:0];
         arl_pkg::CSR_COOLDOWN_LENGTH: cfg_cooldown = value[23:0];
         default: ;
      endcase
   endfunction

   // Roll the window, then apply the checks in priority order
   function automatic arl_pkg::rsp_type judge_request(input arl_pkg::req_type r);
      arl_pkg::rsp_type v;
      logic [32:0]      roll_edge;
      longint           since_last;
      v          = '0;
      roll_edge  = {1'b0, win_start} + {9'b0, cfg_window};
      since_last = longint'(r.now_time) - longint'(last_admit);
      if ({1'b0, r.now_time} >= roll_edge) begin
         win_start = r.now_time;
         win_count = '0;
      end
      if (r.maintenance && !r.override) begin
         v.reason_code = arl_pkg::RSN_MAINT;
      end else if ({1'b0, r.now_time} < cool_until) begin
         v.reason_code = arl_pkg::RSN_COOL;
      end else if (admitted_any && since_last < longint'(cfg_min_gap)) begin
         v.reason_code = arl_pkg::RSN_GAP;
      end else if (win_count >= cfg_max) begin
         v.reason_code = arl_pkg::RSN_WINDOW;
         cool_until    = {1'b0, r.now_time} + {9'b0, cfg_cooldown};
      end else begin
         last_admit    = r.now_time;
         admitted_any  = 1'b1;
         win_count     = win_count + 16'd1;
         v.accepted    = 1'b1;
         v.reason_code = arl_pkg::RSN_OK;
      end
      return v;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one request beat, hold it until taken, then record its verdict
   task automatic offer_request(input logic [31:0] stamp, input logic maint, input logic ovr);
      arl_pkg::req_type r;
      int               gap;
      r.now_time    = stamp;
      r.maintenance = maint;
      r.override    = ovr;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      verdict_q.push_back(judge_request(r));
      requests_sent++;
   endtask

   // Drop valid and wait until every verdict has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the block is idle
   task automatic load_settings(input logic [23:0] window, input logic [23:0] max_word,
                                input logic [23:0] min_gap, input logic [23:0] cooldown);
      logic [arl_pkg::CSR_INDEX_W-1:0] idx_list[4];
      logic [arl_pkg::CSR_DATA_W-1:0]  val_list[4];
      idx_list = '{arl_pkg::CSR_WINDOW_LENGTH, arl_pkg::CSR_MAX_PER_WINDOW,
                   arl_pkg::CSR_MIN_GAP, arl_pkg::CSR_COOLDOWN_LENGTH};
      val_list = '{window, max_word, min_gap, cooldown};
      settle();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data  <= val_list[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         apply_setting(idx_list[i], val_list[i]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   function automatic void advance_cursor(input longint step);
      longint inc;
      inc = longint'($urandom_range(0, int'(step)));
      if (stamp_cursor + inc < STAMP_CEILING) stamp_cursor += inc;
   endfunction

   // Walk through every reason code under the reset settings
   task automatic test_reset_defaults();
      offer_request(32'd0, 1'b1, 1'b0);      // maintenance blocks before anything accepted
      offer_request(32'd0, 1'b1, 1'b1);      // override bypasses maintenance
      offer_request(32'd100, 1'b0, 1'b0);    // inside the minimum gap
      offer_request(32'd600, 1'b0, 1'b1);
      offer_request(32'd1200, 1'b0, 1'b0);   // window now full
      offer_request(32'd1800, 1'b0, 1'b0);   // window limit starts a cooldown
      offer_request(32'd2000, 1'b0, 1'b0);
      offer_request(32'd4799, 1'b0, 1'b0);   // last cycle of the cooldown
      offer_request(32'd4800, 1'b0, 1'b0);   // cooldown over, window still full
      offer_request(32'd10000, 1'b0, 1'b0);  // window rolls exactly at its end
      offer_request(32'd9000, 1'b0, 1'b0);   // time goes backwards
      offer_request(32'd10500, 1'b0, 1'b0);  // gap exactly at the minimum
      offer_request(32'd10999, 1'b1, 1'b1);
      stamp_cursor = longint'(20000);
   endtask

   // Smallest and largest settings
   task automatic test_setting_extremes();
      logic [31:0] t;
      load_settings(24'd1, 24'hFF0001, 24'd0, 24'd0);
      t = stamp_cursor[31:0];
      offer_request(t, 1'b0, 1'b0);
      offer_request(t, 1'b0, 1'b0);          // same time finds the one-slot window full
      offer_request(t, 1'b0, 1'b0);          // zero cooldown does not refuse
      offer_request(t + 32'd1, 1'b0, 1'b0);  // window rolls on every tick of the stamp
      offer_request(t + 32'd1, 1'b1, 1'b1);
      offer_request(t, 1'b0, 1'b0);          // backwards by one is refused by the cooldown before the gap check
      load_settings(FIELD24_MAX, FIELD24_MAX, FIELD24_MAX, FIELD24_MAX);
      t = t + 32'd100;
      offer_request(t, 1'b0, 1'b0);
      offer_request(t + 32'd1, 1'b0, 1'b0);
      offer_request(t + 32'hFFFFFE, 1'b0, 1'b0);
      offer_request(t + 32'hFFFFFF, 1'b0, 1'b0);
      offer_request(t + 32'h1FFFFFE, 1'b1, 1'b0);
      stamp_cursor = longint'(t) + 64'sh2000000;
   endtask

   // Random settings per phase, mostly well-formed traffic with some noise
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [23:0] window, min_gap, cooldown;
      logic [15:0] max_count;
      longint      step, stamp;
      int          roll;
      logic        maint, ovr;
      for (int p = 0; p < phases; p++) begin
         if (p % 4 == 3) begin
            window    = 24'($urandom_range(1 << 20, 24'hFFFFFF));
            max_count = 16'($urandom_range(1, 20));
            min_gap   = 24'($urandom_range(0, 1 << 18));
            cooldown  = 24'($urandom_range(0, 24'hFFFFFF));
         end else begin
            window    = 24'($urandom_range(1, 300));
            max_count = 16'($urandom_range(1, 6));
            min_gap   = 24'($urandom_range(0, 40));
            cooldown  = 24'($urandom_range(0, 200));
         end
         load_settings(window, {8'($urandom), max_count}, min_gap, cooldown);
         sender_steady = ($urandom_range(0, 3) == 0);
         step = longint'(min_gap) + longint'(window) / longint'(max_count) + longint'(1);
         if (step > longint'(1 << 20)) step = longint'(1 << 20);
         advance_cursor(longint'(1 << 27));
         for (int i = 0; i < per_phase; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               maint = 1'b1;
               ovr   = 1'b0;
            end else if (roll < 14) begin
               maint = 1'b1;
               ovr   = 1'b1;
            end else begin
               maint = 1'b0;
               ovr   = 1'($urandom_range(0, 1));
            end
            roll = $urandom_range(0, 99);
            if (roll < 4 && stamp_cursor > step) begin
               stamp = stamp_cursor - longint'($urandom_range(1, int'(step)));
            end else if (roll < 10) begin
               stamp = stamp_cursor;
            end else begin
               advance_cursor(step);
               stamp = stamp_cursor;
            end
            // Hold off now and then until the pipeline is empty
            if ($urandom_range(0, 199) == 0) settle();
            offer_request(stamp[31:0], maint, ovr);
         end
      end
      sender_steady = 1'b0;
   endtask

   // Cooldown past the top of the time range locks out every later request
   task automatic test_time_wrap();
      load_settings(FIELD24_MAX, 24'h000001, 24'd0, FIELD24_MAX);
      offer_request(32'hFFFF_FF00, 1'b0, 1'b0);
      offer_request(32'hFFFF_FF00, 1'b0, 1'b0);
      offer_request(32'hFFFF_FFFF, 1'b0, 1'b0);
      offer_request(32'hFFFF_FFFF, 1'b1, 1'b0);
      offer_request(32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_request(32'h0000_0000, 1'b0, 1'b0);
   endtask

   initial begin
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_setting_extremes();
      test_random_traffic(8, 200);
      test_time_wrap();
      settle();
      repeat (10) @(posedge clock);

      $display("%0d requests over %0d register loads, %0d responses checked", requests_sent,
               settings_loaded, results_seen);
      $display("accepted %0d, maintenance %0d, cooldown %0d, gap %0d, window %0d",
               reason_seen[arl_pkg::RSN_OK], reason_seen[arl_pkg::RSN_MAINT],
               reason_seen[arl_pkg::RSN_COOL], reason_seen[arl_pkg::RSN_GAP],
               reason_seen[arl_pkg::RSN_WINDOW]);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("PASS admission_rate_limiter_unit");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, verdict_q.size());
         $display("FAIL admission_rate_limiter_unit");
      end
      $finish;
   end

endmodule
